@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Shared types, codes and small cell-index helpers for the Playfair block.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = SIDE * SIDE;
  localparam int unsigned LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_LAST = letter_t'(LETTERS - 1);
  localparam cell_t   CELL_COUNT  = cell_t'(CELLS);
  localparam coord_t  COORD_LAST  = coord_t'(SIDE - 1);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_LETTER  = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_ENCRYPT = 2'd3
  } pfe_kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_IGNORED   = 2'd1,
    STATUS_NOT_READY = 2'd2
  } pfe_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_FILL,
    ST_POS_A,
    ST_POS_B,
    ST_SQ_A,
    ST_SQ_B,
    ST_DONE
  } pfe_state_e;

  // Write into the square: slot gets letter, letter gets slot
  typedef struct packed {
    logic    en;
    cell_t   slot;
    letter_t letter;
  } pfe_wr_t;

  typedef struct packed {
    logic    pos_en;
    letter_t pos_addr;
    logic    sq_en;
    cell_t   sq_addr;
  } pfe_rd_t;

  // Clamp to Z and fold J onto I
  function automatic letter_t fold_text(letter_t v);
    letter_t l;
    l = (v > LETTER_LAST) ? LETTER_LAST : v;
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return l;
  endfunction

  function automatic cell_t wrap_cell(cell_t p);
    return (p >= CELL_COUNT) ? cell_t'(p - CELL_COUNT) : p;
  endfunction

  function automatic coord_t cell_row(cell_t p);
    coord_t r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic cell_t cell_of(coord_t r, coord_t k);
    return cell_t'({r, 2'b00}) + cell_t'(r) + cell_t'(k);
  endfunction

  function automatic coord_t cell_col(cell_t p);
    cell_t d;
    d = cell_t'(p - cell_of(cell_row(p), 3'd0));
    return d[2:0];
  endfunction

  function automatic coord_t inc_coord(coord_t x);
    return (x == COORD_LAST) ? 3'd0 : coord_t'(x + 3'd1);
  endfunction

endpackage

@@ src/pfe_if.sv @@
// ----------------------------------------------------------------------------
// Playfair encryptor channels
// Valid/ready request channels for pair requests and cipher results.
// ----------------------------------------------------------------------------
interface pfe_in_if;
  import pfe_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  letter_t    letter_a;
  letter_t    letter_b;

  modport source (output valid, output kind, output letter_a, output letter_b, input ready);
  modport sink   (input valid, input kind, input letter_a, input letter_b, output ready);
endinterface

interface pfe_out_if;
  import pfe_pkg::*;

  logic       valid;
  logic       ready;
  letter_t    cipher_a;
  letter_t    cipher_b;
  logic [1:0] status;

  modport source (output valid, output cipher_a, output cipher_b, output status, input ready);
  modport sink   (input valid, input cipher_a, input cipher_b, input status, output ready);
endinterface

@@ src/pfe_square_mem.sv @@
// ----------------------------------------------------------------------------
// Playfair key square store
// Key square and letter position memories, one write and one read port each.
// ----------------------------------------------------------------------------
module pfe_square_mem (
  input  logic             clk_i,
  input  pfe_pkg::pfe_wr_t wr_i,
  input  pfe_pkg::pfe_rd_t rd_i,
  output pfe_pkg::cell_t   pos_o,
  output pfe_pkg::letter_t sq_o
);
  import pfe_pkg::*;

  letter_t key_square_q [CELLS];
  cell_t   letter_pos_q [LETTERS];
  cell_t   pos_q;
  letter_t sq_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_square_q[wr_i.slot]   <= wr_i.letter;
      letter_pos_q[wr_i.letter] <= wr_i.slot;
    end
  end

  // Registered reads; hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_i.pos_en) begin
      pos_q <= letter_pos_q[rd_i.pos_addr];
    end
    if (rd_i.sq_en) begin
      sq_q <= key_square_q[rd_i.sq_addr];
    end
  end

  assign pos_o = pos_q;
  assign sq_o  = sq_q;

endmodule

@@ src/pfe_cell_unit.sv @@
// ----------------------------------------------------------------------------
// Playfair cell unit
// Maps one letter's cell to its cipher cell, given the partner letter's cell.
// ----------------------------------------------------------------------------
module pfe_cell_unit (
  input  pfe_pkg::cell_t own_i,
  input  pfe_pkg::cell_t other_i,
  output pfe_pkg::cell_t cell_o
);
  import pfe_pkg::*;

  cell_t  own_w;
  cell_t  oth_w;
  coord_t own_row;
  coord_t own_col;
  coord_t oth_row;
  coord_t oth_col;

  always_comb begin
    own_w   = wrap_cell(own_i);
    oth_w   = wrap_cell(other_i);
    own_row = cell_row(own_w);
    own_col = cell_col(own_w);
    oth_row = cell_row(oth_w);
    oth_col = cell_col(oth_w);
    if (own_row == oth_row) begin
      cell_o = cell_of(own_row, inc_coord(own_col));
    end else if (own_col == oth_col) begin
      cell_o = cell_of(inc_coord(own_row), own_col);
    end else begin
      cell_o = cell_of(own_row, oth_col);
    end
  end

endmodule

@@ src/playfair_digraph_encryptor.sv @@
// ----------------------------------------------------------------------------
// Playfair digraph encryptor
// Builds a 5x5 key square from streamed key letters and encrypts letter pairs.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake     | Payload
//  --------+-----+---------------+------------------------------------------
//  in_i    | in  | valid / ready | kind, letter_a, letter_b
//  out_o   | out | valid / ready | cipher_a, cipher_b, status
//
//  One request at a time. An encrypt makes two position reads then two
//  square reads, all through the single registered read port of each
//  memory; a key finish runs the fill walk, which visits all 26 letters,
//  one a cycle.
//  Reset clears the sequencer, the used-letter bits, the fill count and the
//  ready flag; the square memories are written by the key before use.
//  A result waits in the output register; a new request is taken while it
//  waits, and the sequencer holds in its last state only if the next result
//  is ready before the previous one has been taken.
//
module playfair_digraph_encryptor (
  input  logic         clk_i,
  input  logic         rst_ni,
  pfe_in_if.sink       in_i,
  pfe_out_if.source    out_o
);
  import pfe_pkg::*;

  pfe_state_e       state_q, state_d;
  logic [1:0]       kind_q;
  letter_t          la_q;
  letter_t          lb_q;
  logic [LETTERS-1:0] used_q, used_d;
  cell_t            fill_q, fill_d;
  logic             ready_q, ready_d;
  letter_t          walk_q, walk_d;
  cell_t            pa_q, pa_d;
  cell_t            pb_q, pb_d;
  letter_t          ca_q, ca_d;
  logic [1:0]       status_q, status_d;
  logic             enc_q, enc_d;

  logic             ovalid_q, ovalid_d;
  letter_t          oa_q, oa_d;
  letter_t          ob_q, ob_d;
  logic [1:0]       ost_q, ost_d;

  logic             accept;
  logic             out_free;
  letter_t          key_l;
  logic             walk_place;

  pfe_wr_t          wr;
  pfe_rd_t          rd;
  cell_t            pos_rd;
  letter_t          sq_rd;
  cell_t            unit_own;
  cell_t            unit_oth;
  cell_t            unit_cell;

  pfe_square_mem u_mem (
    .clk_i (clk_i),
    .wr_i  (wr),
    .rd_i  (rd),
    .pos_o (pos_rd),
    .sq_o  (sq_rd)
  );

  // The one cell unit serves letter a, then letter b with the roles swapped
  pfe_cell_unit u_cell (
    .own_i   (unit_own),
    .other_i (unit_oth),
    .cell_o  (unit_cell)
  );

  assign in_i.ready     = (state_q == ST_IDLE);
  assign accept         = in_i.valid && in_i.ready;
  assign out_free       = !ovalid_q || out_o.ready;
  assign out_o.valid    = ovalid_q;
  assign out_o.cipher_a = oa_q;
  assign out_o.cipher_b = ob_q;
  assign out_o.status   = ost_q;

  assign key_l      = (la_q == LETTER_J) ? LETTER_I : la_q;
  assign walk_place = (walk_q != LETTER_J) && !used_q[walk_q] && (fill_q < CELL_COUNT);
  assign unit_own   = (state_q == ST_SQ_B) ? pb_q : pa_q;
  assign unit_oth   = (state_q == ST_SQ_B) ? pa_q : pos_rd;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.kind)
            KIND_LETTER:  state_d = ST_KEY;
            KIND_FINISH:  state_d = ST_FILL;
            KIND_ENCRYPT: state_d = ready_q ? ST_POS_A : ST_DONE;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_KEY:   state_d = ST_DONE;
      ST_FILL: begin
        if (walk_q == LETTER_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_POS_A: state_d = ST_POS_B;
      ST_POS_B: state_d = ST_SQ_A;
      ST_SQ_A:  state_d = ST_SQ_B;
      ST_SQ_B:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    used_d   = used_q;
    fill_d   = fill_q;
    ready_d  = ready_q;
    walk_d   = walk_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    ca_d     = ca_q;
    status_d = status_q;
    enc_d    = enc_q;
    ovalid_d = ovalid_q && !out_o.ready;
    oa_d     = oa_q;
    ob_d     = ob_q;
    ost_d    = ost_q;
    wr       = '0;
    rd       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_DONE;
          enc_d    = 1'b0;
          walk_d   = '0;
          case (in_i.kind)
            KIND_START: begin
              used_d  = '0;
              fill_d  = '0;
              ready_d = 1'b0;
            end
            KIND_ENCRYPT: begin
              if (!ready_q) begin
                status_d = STATUS_NOT_READY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_KEY: begin
        // Drop out-of-range letters, letters after finish and repeats
        if (la_q > LETTER_LAST || ready_q) begin
          status_d = STATUS_IGNORED;
        end else if (used_q[key_l]) begin
          status_d = STATUS_IGNORED;
        end else if (fill_q < CELL_COUNT) begin
          wr.en          = 1'b1;
          wr.slot        = fill_q;
          wr.letter      = key_l;
          used_d[key_l]  = 1'b1;
          fill_d         = cell_t'(fill_q + 5'd1);
        end
      end
      ST_FILL: begin
        if (walk_place) begin
          wr.en          = 1'b1;
          wr.slot        = fill_q;
          wr.letter      = walk_q;
          used_d[walk_q] = 1'b1;
          fill_d         = cell_t'(fill_q + 5'd1);
        end
        walk_d = letter_t'(walk_q + 5'd1);
        if (walk_q == LETTER_LAST) begin
          ready_d = 1'b1;
        end
      end
      ST_POS_A: begin
        rd.pos_en   = 1'b1;
        rd.pos_addr = fold_text(la_q);
      end
      ST_POS_B: begin
        rd.pos_en   = 1'b1;
        rd.pos_addr = fold_text(lb_q);
        pa_d        = pos_rd;
      end
      ST_SQ_A: begin
        pb_d       = pos_rd;
        rd.sq_en   = 1'b1;
        rd.sq_addr = unit_cell;
      end
      ST_SQ_B: begin
        rd.sq_en   = 1'b1;
        rd.sq_addr = unit_cell;
        ca_d       = sq_rd;
        enc_d      = 1'b1;
      end
      ST_DONE: begin
        // Hold the result here until the output register is free
        if (out_free) begin
          ovalid_d = 1'b1;
          oa_d     = enc_q ? ca_q : '0;
          ob_d     = enc_q ? sq_rd : '0;
          ost_d    = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      fill_q   <= '0;
      ready_q  <= 1'b0;
      ovalid_q <= 1'b0;
      enc_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      fill_q   <= fill_d;
      ready_q  <= ready_d;
      ovalid_q <= ovalid_d;
      enc_q    <= enc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      la_q   <= in_i.letter_a;
      lb_q   <= in_i.letter_b;
    end
    walk_q   <= walk_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    ca_q     <= ca_d;
    status_q <= status_d;
    oa_q     <= oa_d;
    ob_q     <= ob_d;
    ost_q    <= ost_d;
  end

  // Every placed letter is marked used, and nothing else is
  a_used_matches_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(fill_q))
    else $error("used letters and fill count disagree");

  a_ready_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> fill_q == CELL_COUNT)
    else $error("square marked ready while not full");

  a_fill_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && walk_q == LETTER_LAST) |=> ready_q)
    else $error("fill walk ended without marking the square ready");

  a_letter_on_key_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEY) |-> kind_q == KIND_LETTER)
    else $error("key placement entered for a request that is not a key letter");

  a_no_cipher_when_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ost_q != STATUS_DONE) |-> (oa_q == '0 && ob_q == '0))
    else $error("cipher letters set on a result that did not encrypt");

endmodule
